/* design/dq_pkg.sv */
`timescale 1ns / 1ps

package dq_pkg;

   localparam int DATA_W        = 32;
   localparam int DEPTH_DEFAULT = 16;

   typedef enum logic [1:0] {
      MODE_PUSH_FRONT = 2'd0,
      MODE_PUSH_BACK  = 2'd1,
      MODE_POP_FRONT  = 2'd2,
      MODE_POP_BACK   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_DONE       = 2'd0,
      STATUS_POP_EMPTY  = 2'd1,
      STATUS_PUSH_FULL  = 2'd2,
      STATUS_UNUSED     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_LOAD,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic capture;
      logic execute;
      logic read;
      logic load;
   } dq_cmd_type;

endpackage

/* design/double_ended_queue.sv */
`timescale 1ns / 1ps
// Bounded double-ended queue of signed 32-bit values in a ring buffer.
// Request channel: req_valid/req_stall with req_mode (push front, push back,
// pop front, pop back) and req_push_value. Every request yields exactly one
// response on rsp_valid/rsp_stall: status, popped value, front and back
// values after the operation, occupancy and an empty flag.
// The response is valid once a taken request has passed through capture,
// update/write, memory read and load. The next request can be taken
// in the same cycle the response is taken, and no earlier; the
// registered-read memory port sequence sets these steps.
// A pop on an empty queue or a push on a full one reports an error status
// and leaves the contents unchanged.
// Reset empties the queue (pointers and count cleared); stored entries are
// not cleared and need no clearing pass.
// While a response waits under rsp_stall it holds steady and no new request
// is taken.
module double_ended_queue #(
   parameter  int DEPTH      = dq_pkg::DEPTH_DEFAULT,
   localparam int CountWidth = $clog2(DEPTH + 1)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_mode,
   input  logic signed [dq_pkg::DATA_W-1:0] req_push_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [1:0]                       rsp_status,
   output logic signed [dq_pkg::DATA_W-1:0] rsp_popped_value,
   output logic signed [dq_pkg::DATA_W-1:0] rsp_front_value,
   output logic signed [dq_pkg::DATA_W-1:0] rsp_back_value,
   output logic [CountWidth-1:0]            rsp_occupancy,
   output logic                             rsp_is_empty
);
   import dq_pkg::*;

   dq_cmd_type cmd;

   dq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   dq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_mode         (req_mode),
      .req_push_value   (req_push_value),
      .rsp_status       (rsp_status),
      .rsp_popped_value (rsp_popped_value),
      .rsp_front_value  (rsp_front_value),
      .rsp_back_value   (rsp_back_value),
      .rsp_occupancy    (rsp_occupancy),
      .rsp_is_empty     (rsp_is_empty)
   );

endmodule

/* design/dq_ctrl.sv */
`timescale 1ns / 1ps

module dq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output dq_pkg::dq_cmd_type cmd
);
   import dq_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = ST_READ;
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            req_stall = rsp_stall;
            if (!rsp_stall) begin
               if (req_valid) begin
                  cmd.capture = 1'b1;
                  state_in    = ST_EXEC;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* design/dq_datapath.sv */
`timescale 1ns / 1ps

module dq_datapath #(
   parameter  int DEPTH      = dq_pkg::DEPTH_DEFAULT,
   localparam int AddrWidth  = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CountWidth = $clog2(DEPTH + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  dq_pkg::dq_cmd_type          cmd,
   input  logic [1:0]                  req_mode,
   input  logic signed [dq_pkg::DATA_W-1:0] req_push_value,
   output logic [1:0]                  rsp_status,
   output logic signed [dq_pkg::DATA_W-1:0] rsp_popped_value,
   output logic signed [dq_pkg::DATA_W-1:0] rsp_front_value,
   output logic signed [dq_pkg::DATA_W-1:0] rsp_back_value,
   output logic [CountWidth-1:0]       rsp_occupancy,
   output logic                        rsp_is_empty
);
   import dq_pkg::*;

   logic [DATA_W-1:0] mem [DEPTH];

   mode_type               mode_ff;
   logic [DATA_W-1:0]      value_ff;
   logic [AddrWidth-1:0]   front_ff, front_in;
   logic [AddrWidth-1:0]   back_ff, back_in;
   logic [CountWidth-1:0]  count_ff, count_in;
   status_type             status_ff;
   logic                   pop_taken_ff;
   logic [DATA_W-1:0]      popped_ff;
   logic [DATA_W-1:0]      front_val_ff;
   logic [DATA_W-1:0]      back_val_ff;
   logic [DATA_W-1:0]      rd_a_ff;
   logic [DATA_W-1:0]      rd_b_ff;

   logic                   is_push;
   logic                   op_ok;
   logic [AddrWidth-1:0]   front_inc, front_dec, back_inc, back_dec;
   logic                   wr_en;
   logic [AddrWidth-1:0]   wr_addr;
   logic [AddrWidth-1:0]   rd_a_addr;

   assign front_inc = (front_ff == AddrWidth'(DEPTH - 1)) ? '0 : front_ff + AddrWidth'(1);
   assign front_dec = (front_ff == '0) ? AddrWidth'(DEPTH - 1) : front_ff - AddrWidth'(1);
   assign back_inc  = (back_ff == AddrWidth'(DEPTH - 1)) ? '0 : back_ff + AddrWidth'(1);
   assign back_dec  = (back_ff == '0) ? AddrWidth'(DEPTH - 1) : back_ff - AddrWidth'(1);

   assign is_push = (mode_ff == MODE_PUSH_FRONT) || (mode_ff == MODE_PUSH_BACK);
   assign op_ok   = is_push ? (count_ff != CountWidth'(DEPTH)) : (count_ff != '0);

   assign wr_en   = cmd.execute && is_push && op_ok;
   assign wr_addr = (mode_ff == MODE_PUSH_FRONT) ? front_dec : back_ff;

   // exec: pop address; read: new front (port B always reads new back)
   assign rd_a_addr = (cmd.execute && mode_ff == MODE_POP_BACK) ? back_dec : front_ff;

   always_comb begin
      front_in = front_ff;
      back_in  = back_ff;
      count_in = count_ff;
      if (cmd.execute && op_ok) begin
         case (mode_ff)
            MODE_PUSH_FRONT: begin
               front_in = front_dec;
               count_in = count_ff + CountWidth'(1);
            end
            MODE_PUSH_BACK: begin
               back_in  = back_inc;
               count_in = count_ff + CountWidth'(1);
            end
            MODE_POP_FRONT: begin
               front_in = front_inc;
               count_in = count_ff - CountWidth'(1);
            end
            MODE_POP_BACK: begin
               back_in  = back_dec;
               count_in = count_ff - CountWidth'(1);
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         back_ff  <= '0;
         count_ff <= '0;
      end else begin
         front_ff <= front_in;
         back_ff  <= back_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= value_ff;
      end
      rd_a_ff <= mem[rd_a_addr];
      rd_b_ff <= mem[back_dec];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff  <= mode_type'(req_mode);
         value_ff <= req_push_value;
      end
      if (cmd.execute) begin
         status_ff    <= op_ok ? STATUS_DONE : (is_push ? STATUS_PUSH_FULL : STATUS_POP_EMPTY);
         pop_taken_ff <= op_ok && !is_push;
      end
      if (cmd.read) begin
         popped_ff <= pop_taken_ff ? rd_a_ff : '0;
      end
      if (cmd.load) begin
         front_val_ff <= (count_ff == '0) ? '0 : rd_a_ff;
         back_val_ff  <= (count_ff == '0) ? '0 : rd_b_ff;
      end
   end

   assign rsp_status       = status_ff;
   assign rsp_popped_value = popped_ff;
   assign rsp_front_value  = front_val_ff;
   assign rsp_back_value   = back_val_ff;
   assign rsp_occupancy    = count_ff;
   assign rsp_is_empty     = (count_ff == '0);

endmodule

/* design/dq_checker.sv */
`timescale 1ns / 1ps

module dq_checker #(
   parameter  int DEPTH      = dq_pkg::DEPTH_DEFAULT,
   localparam int CountWidth = $clog2(DEPTH + 1)
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [1:0]                       rsp_status,
   input logic signed [dq_pkg::DATA_W-1:0] rsp_popped_value,
   input logic signed [dq_pkg::DATA_W-1:0] rsp_front_value,
   input logic signed [dq_pkg::DATA_W-1:0] rsp_back_value,
   input logic [CountWidth-1:0]            rsp_occupancy,
   input logic                             rsp_is_empty
);
   import dq_pkg::*;

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_occupancy == '0)))
      else $error("empty flag disagrees with occupancy");

   a_empty_values: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_empty) |-> (rsp_front_value == '0 && rsp_back_value == '0))
      else $error("empty queue shows nonzero front or back");

   a_pop_refused: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_POP_EMPTY) |->
         (rsp_is_empty && rsp_popped_value == '0))
      else $error("pop refused on a non-empty queue");

   a_push_refused: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_PUSH_FULL) |->
         (rsp_occupancy == CountWidth'(DEPTH)))
      else $error("push refused on a queue that is not full");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_occupancy)))
      else $error("stalled response dropped or changed");

endmodule

bind double_ended_queue dq_checker #(
   .DEPTH (DEPTH)
) u_dq_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_status       (rsp_status),
   .rsp_popped_value (rsp_popped_value),
   .rsp_front_value  (rsp_front_value),
   .rsp_back_value   (rsp_back_value),
   .rsp_occupancy    (rsp_occupancy),
   .rsp_is_empty     (rsp_is_empty)
);

/* verif/double_ended_queue_tb.sv */
`timescale 1ns / 1ps

module double_ended_queue_tb;
   import dq_pkg::*;

   localparam int DEQ_DEPTH   = DEPTH_DEFAULT;
   localparam int QUIET_LIMIT = 2000;
   localparam int RANDOM_ITEMS_PER_PHASE = 450;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] popped;
      logic [31:0] front;
      logic [31:0] back;
      logic [4:0]  occupancy;
      logic        is_empty;
   } deque_snapshot_type;

   typedef struct {
      mode_type           mode;
      logic [31:0]        value;
      bit                 typed;
      deque_snapshot_type want;
   } stimulus_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_mode = MODE_PUSH_BACK;
   logic signed [31:0] req_push_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic signed [31:0] rsp_popped_value;
   logic signed [31:0] rsp_front_value;
   logic signed [31:0] rsp_back_value;
   logic [4:0] rsp_occupancy;
   logic rsp_is_empty;

   // mirror of the ring buffer
   logic [31:0] mirror_store [DEQ_DEPTH];
   int mirror_front = 0;
   int mirror_back  = 0;
   int mirror_count = 0;

   deque_snapshot_type pending_results[$];
   stimulus_row_type   directed_rows[$];

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int mismatch_count     = 0;
   int requests_taken     = 0;
   int responses_seen     = 0;
   int full_refusals      = 0;
   int empty_refusals     = 0;
   int quiet_cycles       = 0;
   bit filling            = 1'b1;

   double_ended_queue #(
      .DEPTH(DEQ_DEPTH)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_push_value  (req_push_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_popped_value(rsp_popped_value),
      .rsp_front_value (rsp_front_value),
      .rsp_back_value  (rsp_back_value),
      .rsp_occupancy   (rsp_occupancy),
      .rsp_is_empty    (rsp_is_empty)
   );

   always #4 clock = ~clock;

   function automatic deque_snapshot_type apply_to_mirror(input mode_type m,
                                                         input logic [31:0] v);
      deque_snapshot_type r;
      r = '0;
      r.status = STATUS_DONE;
      if (m == MODE_PUSH_FRONT || m == MODE_PUSH_BACK) begin
         if (mirror_count >= DEQ_DEPTH) begin
            r.status = STATUS_PUSH_FULL;
         end else if (m == MODE_PUSH_FRONT) begin
            mirror_front = (mirror_front + DEQ_DEPTH - 1) % DEQ_DEPTH;
            mirror_store[mirror_front] = v;
            mirror_count++;
         end else begin
            mirror_store[mirror_back] = v;
            mirror_back = (mirror_back + 1) % DEQ_DEPTH;
            mirror_count++;
         end
      end else begin
         if (mirror_count == 0) begin
            r.status = STATUS_POP_EMPTY;
         end else if (m == MODE_POP_FRONT) begin
            r.popped = mirror_store[mirror_front];
            mirror_front = (mirror_front + 1) % DEQ_DEPTH;
            mirror_count--;
         end else begin
            mirror_back = (mirror_back + DEQ_DEPTH - 1) % DEQ_DEPTH;
            r.popped = mirror_store[mirror_back];
            mirror_count--;
         end
      end
      if (mirror_count != 0) begin
         r.front = mirror_store[mirror_front];
         r.back  = mirror_store[(mirror_back + DEQ_DEPTH - 1) % DEQ_DEPTH];
      end
      r.occupancy = 5'(mirror_count);
      r.is_empty  = (mirror_count == 0);
      return r;
   endfunction

   task automatic report_mismatch(input string note);
      mismatch_count++;
      $display("[%0t] MISMATCH: %s", $realtime, note);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("response %0d %s got 0x%h expected 0x%h",
                                   responses_seen, name, got, want));
   endtask

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic issue_request(input mode_type m, input logic [31:0] v,
                                input bit typed, input deque_snapshot_type want);
      deque_snapshot_type predicted;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= m;
      req_push_value <= v;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      predicted = apply_to_mirror(m, v);
      if (predicted.status == STATUS_PUSH_FULL) full_refusals++;
      if (predicted.status == STATUS_POP_EMPTY) empty_refusals++;
      requests_taken++;
      pending_results.insert(pending_results.size(), typed ? want : predicted);
      @(negedge clock);
   endtask

   task automatic add_checked(input mode_type m, input logic [31:0] v);
      stimulus_row_type row;
      row.mode  = m;
      row.value = v;
      row.typed = 1'b0;
      row.want  = '0;
      directed_rows.insert(directed_rows.size(), row);
   endtask

   task automatic add_typed(input mode_type m, input logic [31:0] v,
                            input status_type s, input logic [31:0] popped,
                            input logic [31:0] front, input logic [31:0] back,
                            input int occ, input bit empty);
      stimulus_row_type row;
      row.mode  = m;
      row.value = v;
      row.typed = 1'b1;
      row.want  = '{s, popped, front, back, 5'(occ), empty};
      directed_rows.insert(directed_rows.size(), row);
   endtask

   task automatic random_phase(input int idle_pct, input int stall_pct);
      mode_type    m;
      logic [31:0] v;
      int          pick;
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      for (int n = 0; n < RANDOM_ITEMS_PER_PHASE; n++) begin
         if (mirror_count == DEQ_DEPTH) filling = 1'b0;
         if (mirror_count == 0) filling = 1'b1;
         if ($urandom_range(99) == 0) filling = ~filling;
         pick = $urandom_range(99);
         if (pick < 8) begin
            m = mode_type'($urandom_range(3));
         end else if (pick < (filling ? 78 : 30)) begin
            m = $urandom_range(1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
         end else begin
            m = $urandom_range(1) ? MODE_POP_FRONT : MODE_POP_BACK;
         end
         case ($urandom_range(3))
            0: v = 32'($urandom_range(255));
            1: begin
               case ($urandom_range(3))
                  0: v = 32'h0000_0000;
                  1: v = 32'hffff_ffff;
                  2: v = 32'h7fff_ffff;
                  default: v = 32'h8000_0000;
               endcase
            end
            default: v = $urandom;
         endcase
         issue_request(m, v, 1'b0, '0);
      end
   endtask

   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < receiver_stall_pct);
   end

   always @(posedge clock) begin
      deque_snapshot_type want;
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         responses_seen++;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("response %0d with no request outstanding",
                                      responses_seen));
         end else begin
            want = pending_results[0];
            pending_results.delete(0);
            check_field("status", 32'(rsp_status), 32'(want.status));
            check_field("popped_value", rsp_popped_value, want.popped);
            check_field("front_value", rsp_front_value, want.front);
            check_field("back_value", rsp_back_value, want.back);
            check_field("occupancy", 32'(rsp_occupancy), 32'(want.occupancy));
            check_field("is_empty", 32'(rsp_is_empty), 32'(want.is_empty));
         end
      end
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("[%0t] watchdog: no handshake in %0d cycles", $realtime, QUIET_LIMIT);
      $display("double_ended_queue_tb: errors");
      $finish;
   end

   initial begin
      add_typed(MODE_POP_FRONT, 32'h1111_1111, STATUS_POP_EMPTY, 0, 0, 0, 0, 1'b1);
      add_typed(MODE_POP_BACK, 32'hffff_ffff, STATUS_POP_EMPTY, 0, 0, 0, 0, 1'b1);
      add_typed(MODE_PUSH_BACK, 32'h7fff_ffff, STATUS_DONE, 0,
                32'h7fff_ffff, 32'h7fff_ffff, 1, 1'b0);
      add_typed(MODE_PUSH_FRONT, 32'h8000_0000, STATUS_DONE, 0,
                32'h8000_0000, 32'h7fff_ffff, 2, 1'b0);
      add_typed(MODE_POP_BACK, 32'h0, STATUS_DONE, 32'h7fff_ffff,
                32'h8000_0000, 32'h8000_0000, 1, 1'b0);
      // last element out
      add_typed(MODE_POP_FRONT, 32'h0, STATUS_DONE, 32'h8000_0000, 0, 0, 0, 1'b1);
      add_checked(MODE_PUSH_FRONT, 32'hffff_ffff);
      add_checked(MODE_PUSH_FRONT, 32'h0000_0000);
      add_checked(MODE_PUSH_FRONT, 32'h0000_0001);
      add_checked(MODE_PUSH_FRONT, 32'h5555_5555);
      add_checked(MODE_PUSH_FRONT, 32'haaaa_aaaa);
      add_checked(MODE_PUSH_FRONT, 32'h7fff_fffe);
      add_checked(MODE_PUSH_FRONT, 32'h8000_0001);
      add_checked(MODE_PUSH_FRONT, 32'h1234_5678);
      add_checked(MODE_PUSH_BACK, 32'h8000_0000);
      add_checked(MODE_PUSH_BACK, 32'h7fff_ffff);
      add_checked(MODE_PUSH_BACK, 32'h0f0f_0f0f);
      add_checked(MODE_PUSH_BACK, 32'hf0f0_f0f0);
      add_checked(MODE_PUSH_BACK, 32'h3333_3333);
      add_checked(MODE_PUSH_BACK, 32'hcccc_cccc);
      add_checked(MODE_PUSH_BACK, 32'h0000_00ff);
      add_checked(MODE_PUSH_BACK, 32'h89ab_cdef);
      // full
      add_typed(MODE_PUSH_FRONT, 32'hdead_beef, STATUS_PUSH_FULL, 0,
                32'h1234_5678, 32'h89ab_cdef, 16, 1'b0);
      add_typed(MODE_PUSH_BACK, 32'hdead_beef, STATUS_PUSH_FULL, 0,
                32'h1234_5678, 32'h89ab_cdef, 16, 1'b0);
      add_checked(MODE_POP_FRONT, 32'h0);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i])
         issue_request(directed_rows[i].mode, directed_rows[i].value,
                       directed_rows[i].typed, directed_rows[i].want);

      random_phase(0, 0);
      random_phase(46, 0);
      // drain completely before going on
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      random_phase(0, 46);
      random_phase(7, 7);
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("%0d requests, %0d responses checked; %0d pushes refused when full,",
               requests_taken, responses_seen, full_refusals);
      $display("%0d pops refused when empty, under four idle/stall mixes", empty_refusals);
      if (mismatch_count == 0)
         $display("double_ended_queue_tb: clean");
      else
         $display("double_ended_queue_tb: errors");
      $finish;
   end

endmodule

/* double_ended_queue.f */
design/dq_pkg.sv
design/dq_ctrl.sv
design/dq_datapath.sv
design/double_ended_queue.sv
design/dq_checker.sv
verif/double_ended_queue_tb.sv
